[sv/mclc_pkg.sv]
// ----------------------------------------------------------------------------
// mclc_pkg
// Shared types, character codes and symbol tables for the Morse line codec.
// ----------------------------------------------------------------------------
package mclc_pkg;

    localparam int MaxRes = 6;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [2:0] BAD_TOKEN = 3'd5;

    // letter A+i: element count, elements with the first as MSB (dash = 1)
    localparam logic [2:0] SYM_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] SYM_BITS [26] = '{
        4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
        4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
    } mclc_res_t;

    typedef struct packed {
        mclc_res_t [MaxRes-1:0] res;
        logic      [2:0]        count;
    } mclc_batch_t;

    typedef struct packed {
        logic       found;
        logic [7:0] ch;
    } mclc_match_t;

    function automatic mclc_match_t mclc_lookup(input logic [2:0] cnt,
                                                input logic [3:0] bits);
        mclc_match_t m;
        m.found = 1'b0;
        m.ch    = CH_QMARK;
        for (int i = 0; i < 26; i++)
        begin
            if (!m.found && SYM_LEN[i] == cnt && SYM_BITS[i] == bits)
            begin
                m.found = 1'b1;
                m.ch    = CH_A + 8'(i);
            end
        end
        return m;
    endfunction

endpackage

[sv/morse_code_line_codec.sv]
// ----------------------------------------------------------------------------
// morse_code_line_codec
// Morse line codec, letters A to Z: encodes or decodes one line per pass.
//
//   channel | signals                          | dir
//   in      | in_valid in_stall char_code      | in
//           | line_end                         |
//   out     | out_valid out_stall out_char     | out
//           | is_error last                    |
//
// A character waits in the input register, then its 0..6 beats leave the
// result register one per cycle while out_stall is low; a character that
// gives no beat loads nothing. Rate is set by the result register's play-out.
// Reset puts the codec at the start of a line in encode mode.
// Output stall holds the result register; the input register stalls only
// while its batch cannot enter the result register.
// ----------------------------------------------------------------------------
module morse_code_line_codec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       is_error,
    output logic       last
);
    import mclc_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  char_reg;
    logic        end_reg;
    logic        advance, load, free;
    mclc_batch_t batch;

    mclc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .char_code (char_reg),
        .line_end  (end_reg),
        .batch     (batch)
    );

    mclc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .batch     (batch),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .is_error  (is_error),
        .last      (last)
    );

    always_comb
    begin
        advance  = in_vld_reg && (batch.count == 3'd0 || free);
        load     = advance && batch.count != 3'd0;
        in_stall = in_vld_reg && !advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_code;
            end_reg  <= line_end;
        end
    end

    a_err_is_qmark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> out_char == CH_QMARK)
        else $error("error beat is not a question mark");

    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == CH_NL |-> last)
        else $error("newline beat not last of its batch");

    a_batch_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("batch dropped before its last beat");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_valid)
        else $error("input stalled with nothing pending");

endmodule

[sv/mclc_core.sv]
// ----------------------------------------------------------------------------
// mclc_core
// Line state and per-character codec logic; builds the result batch.
// ----------------------------------------------------------------------------
module mclc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           char_code,
    input  logic                 line_end,
    output mclc_pkg::mclc_batch_t batch
);
    import mclc_pkg::*;

    logic       line_start_reg, line_start_next;
    logic       decode_reg, decode_next;
    logic [2:0] elem_cnt_reg, elem_cnt_next;
    logic [3:0] elem_bits_reg, elem_bits_next;

    logic        is_dot, is_dash, is_elem, is_space, is_letter, mode;
    logic [2:0]  cnt0, cnt1, tok_cnt, len;
    logic [3:0]  bits0, bits1, tok_bits, sbits;
    logic [4:0]  idx;
    logic        flush_en, has_tok;
    mclc_match_t match;
    mclc_res_t   tok_res;

    always_comb
    begin
        is_dot    = char_code == CH_DOT;
        is_dash   = char_code == CH_DASH;
        is_elem   = is_dot || is_dash;
        is_space  = char_code == CH_SPACE;
        is_letter = char_code >= CH_A && char_code <= CH_Z;
        mode      = line_start_reg ? is_elem : decode_reg;
        cnt0      = line_start_reg ? 3'd0 : elem_cnt_reg;
        bits0     = line_start_reg ? 4'd0 : elem_bits_reg;

        cnt1  = cnt0;
        bits1 = bits0;
        if (is_elem)
        begin
            if (cnt0 < 3'd4)
            begin
                bits1 = {bits0[2:0], is_dash};
                cnt1  = cnt0 + 3'd1;
            end
            else
            begin
                cnt1 = BAD_TOKEN;
            end
        end
        else if (is_space)
        begin
            cnt1  = 3'd0;
            bits1 = 4'd0;
        end
        else
        begin
            cnt1 = BAD_TOKEN;
        end

        tok_cnt  = is_space ? cnt0 : cnt1;
        tok_bits = is_space ? bits0 : bits1;
        flush_en = is_space || line_end;
        has_tok  = flush_en && tok_cnt != 3'd0;
        match    = mclc_lookup(tok_cnt, tok_bits);
        tok_res.ch  = match.ch;
        tok_res.err = !match.found;

        idx   = is_letter ? 5'(char_code - CH_A) : 5'd0;
        len   = SYM_LEN[idx];
        sbits = SYM_BITS[idx];

        batch.res   = '0;
        batch.count = 3'd0;
        if (mode)
        begin
            if (has_tok)
            begin
                batch.res[0] = tok_res;
            end
            if (line_end)
            begin
                batch.res[3'(has_tok)] = '{ch: CH_NL, err: 1'b0};
            end
            batch.count = 3'(has_tok) + 3'(line_end);
        end
        else if (is_letter)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (3'(j) < len)
                begin
                    batch.res[j].ch  = sbits[2'(len - 3'(j) - 3'd1)] ? CH_DASH : CH_DOT;
                    batch.res[j].err = 1'b0;
                end
            end
            batch.res[len] = '{ch: CH_SPACE, err: 1'b0};
            if (line_end)
            begin
                batch.res[len + 3'd1] = '{ch: CH_NL, err: 1'b0};
            end
            batch.count = len + 3'd1 + 3'(line_end);
        end
        else
        begin
            batch.res[0] = '{ch: CH_QMARK, err: 1'b1};
            if (line_end)
            begin
                batch.res[1] = '{ch: CH_NL, err: 1'b0};
            end
            batch.count = 3'd1 + 3'(line_end);
        end

        if (line_end)
        begin
            line_start_next = 1'b1;
            decode_next     = 1'b0;
            elem_cnt_next   = 3'd0;
            elem_bits_next  = 4'd0;
        end
        else
        begin
            line_start_next = 1'b0;
            decode_next     = mode;
            elem_cnt_next   = mode ? cnt1 : 3'd0;
            elem_bits_next  = mode ? bits1 : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg <= 1'b1;
            decode_reg     <= 1'b0;
            elem_cnt_reg   <= 3'd0;
            elem_bits_reg  <= 4'd0;
        end
        else if (step)
        begin
            line_start_reg <= line_start_next;
            decode_reg     <= decode_next;
            elem_cnt_reg   <= elem_cnt_next;
            elem_bits_reg  <= elem_bits_next;
        end
    end

endmodule

[sv/mclc_outbuf.sv]
// ----------------------------------------------------------------------------
// mclc_outbuf
// Result register: holds one batch and plays it out one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module mclc_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  mclc_pkg::mclc_batch_t batch,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_char,
    output logic                  is_error,
    output logic                  last
);
    import mclc_pkg::*;

    mclc_res_t  buf_reg [MaxRes];
    logic [2:0] cnt_reg;
    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic       take, take_last;

    always_comb
    begin
        out_valid = valid_reg;
        out_char  = buf_reg[idx_reg].ch;
        is_error  = buf_reg[idx_reg].err;
        last      = idx_reg == cnt_reg - 3'd1;
        take      = valid_reg && !out_stall;
        take_last = take && last;
        free      = !valid_reg || take_last;
        idx_next  = idx_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MaxRes; i++)
            begin
                buf_reg[i] <= batch.res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 3'd0;
            idx_reg   <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= batch.count;
            idx_reg   <= 3'd0;
        end
        else if (take_last)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[verif/morse_code_line_codec_tb.sv]
// ----------------------------------------------------------------------------
// morse_code_line_codec_tb
// Self-checking bench for the Morse line codec. Character beats are queued
// up front and driven with random gaps; result beats are checked one by one
// against a behavioral codec model run on every accepted character.
// Directed lines cover encode, decode, foreign characters and bad tokens,
// followed by random lines that are mostly well formed.
// ----------------------------------------------------------------------------
module morse_code_line_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mclc_pkg::*;

    localparam int unsigned IDLE_LIMIT       = 1000;
    localparam int unsigned DRAIN_CYCLES     = 20;
    localparam int unsigned LONG_HOLD        = 120;
    localparam int unsigned HOLD_AFTER_BEATS = 120;
    localparam int unsigned RANDOM_CHARS     = 255;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       drain_first;
    } char_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       fin;
    } codec_beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'h00;
    logic       line_end  = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       is_error;
    logic       last;

    char_item_t  char_queue [$];
    codec_beat_t expected_beats [$];
    codec_beat_t new_beats [$];

    // codec model state
    logic  at_sol    = 1'b1;
    logic  decoding  = 1'b0;
    string token     = "";
    logic  token_bad = 1'b0;

    logic        in_beat_taken       = 1'b0;
    logic        long_hold_done      = 1'b0;
    int unsigned send_gap            = 0;
    int unsigned hold_left           = 0;
    int unsigned idle_cycles         = 0;
    int unsigned mismatches          = 0;
    int unsigned chars_taken         = 0;
    int unsigned beats_checked       = 0;
    int unsigned error_beats         = 0;
    int unsigned encode_lines        = 0;
    int unsigned decode_lines        = 0;
    int unsigned backpressure_cycles = 0;

    morse_code_line_codec uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .line_end  (line_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .is_error  (is_error),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic string morse_of(input int idx);
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            default: return "--..";
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_beat(input logic [7:0] ch, input logic err);
        new_beats.push_back('{ch: ch, err: err, fin: 1'b0});
    endtask

    task automatic flush_token();
        bit hit;
        hit = 1'b0;
        if (token_bad || token.len() != 0)
        begin
            if (!token_bad)
            begin
                for (int k = 0; k < 26; k++)
                begin
                    if (!hit && morse_of(k) == token)
                    begin
                        push_beat(CH_A + 8'(k), 1'b0);
                        hit = 1'b1;
                    end
                end
            end
            if (!hit)
                push_beat(CH_QMARK, 1'b1);
        end
        token     = "";
        token_bad = 1'b0;
    endtask

    task automatic predict_codec_beats(input logic [7:0] ch, input logic eol);
        string pat;
        new_beats.delete();
        if (at_sol)
        begin
            decoding  = (ch == CH_DOT || ch == CH_DASH);
            at_sol    = 1'b0;
            token     = "";
            token_bad = 1'b0;
            if (decoding)
                decode_lines++;
            else
                encode_lines++;
        end
        if (decoding)
        begin
            if (ch == CH_DOT || ch == CH_DASH)
            begin
                if (!token_bad && token.len() < 4)
                begin
                    if (ch == CH_DASH)
                        token = {token, "-"};
                    else
                        token = {token, "."};
                end
                else
                    token_bad = 1'b1;
            end
            else if (ch == CH_SPACE)
                flush_token();
            else
                token_bad = 1'b1;
            if (eol)
                flush_token();
        end
        else if (ch >= CH_A && ch <= CH_Z)
        begin
            pat = morse_of(int'(ch - CH_A));
            for (int k = 0; k < pat.len(); k++)
                push_beat(pat.getc(k), 1'b0);
            push_beat(CH_SPACE, 1'b0);
        end
        else
            push_beat(CH_QMARK, 1'b1);
        if (eol)
        begin
            push_beat(CH_NL, 1'b0);
            at_sol    = 1'b1;
            decoding  = 1'b0;
            token     = "";
            token_bad = 1'b0;
        end
        if (new_beats.size() != 0)
            new_beats[new_beats.size() - 1].fin = 1'b1;
        foreach (new_beats[i])
            expected_beats.push_back(new_beats[i]);
    endtask

    task automatic add_char(input logic [7:0] ch, input logic eol, input logic drain);
        char_queue.push_back('{ch: ch, eol: eol, drain_first: drain});
    endtask

    task automatic queue_text(input string s, input logic close_line);
        for (int i = 0; i < s.len(); i++)
            add_char(s.getc(i), close_line && i == s.len() - 1, 1'b0);
    endtask

    // character driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_beat_taken)
        begin
            // stalled: hold the beat
        end
        else if (send_gap != 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (char_queue.size() != 0 &&
                 !(char_queue[0].drain_first && expected_beats.size() != 0))
        begin
            in_valid  <= 1'b1;
            char_code <= char_queue[0].ch;
            line_end  <= char_queue[0].eol;
            void'(char_queue.pop_front());
            send_gap  <= pick_gap();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && beats_checked >= HOLD_AFTER_BEATS)
        begin
            out_stall      <= 1'b1;
            hold_left      <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall <= 1'b1;
            hold_left <= pick_gap();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : monitor
        codec_beat_t want;
        if (!rst_n)
        begin
            in_beat_taken <= 1'b0;
        end
        else
        begin
            in_beat_taken <= (in_valid === 1'b1 && in_stall === 1'b0);
            if (in_valid === 1'b1 && in_stall === 1'b1)
                backpressure_cycles++;
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                predict_codec_beats(char_code, line_end);
                chars_taken++;
            end
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat: char %02h err %b last %b",
                                              out_char, is_error, last));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_char !== want.ch || is_error !== want.err || last !== want.fin)
                        report_mismatch($sformatf(
                            "beat %0d: got char %02h err %b last %b, want %02h %b %b",
                            beats_checked, out_char, is_error, last,
                            want.ch, want.err, want.fin));
                end
                beats_checked++;
                if (is_error === 1'b1)
                    error_beats++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n ||
            (in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned random_chars;
        int unsigned lines;
        int unsigned kind;
        int unsigned n;
        int unsigned ntok;
        int unsigned len;
        int unsigned total;
        logic        drain;
        logic [7:0]  line_chars [$];

        // directed lines
        queue_text("AZ", 1'b1);
        add_char(8'h00, 1'b0, 1'b0);
        add_char(8'hFF, 1'b0, 1'b0);
        queue_text("a B", 1'b1);
        queue_text(".-  ----- ", 1'b0);
        queue_text("-x ", 1'b1);
        queue_text("..--", 1'b1);
        queue_text(".", 1'b1);

        // random lines, mostly well formed
        random_chars = 0;
        lines        = 0;
        while (random_chars < RANDOM_CHARS)
        begin
            line_chars.delete();
            drain = (lines == 0 || lines == 40);
            kind  = $urandom_range(0, 99);
            if (kind < 45)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 9) != 0)
                        line_chars.push_back(CH_A + 8'($urandom_range(0, 25)));
                    else
                        line_chars.push_back(8'($urandom_range(0, 255)));
                end
            end
            else if (kind < 85)
            begin
                ntok = $urandom_range(1, 4);
                for (int t = 0; t < ntok; t++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        len = $urandom_range(5, 7);
                    else
                        len = $urandom_range(1, 4);
                    for (int e = 0; e < len; e++)
                    begin
                        line_chars.push_back($urandom_range(0, 1) ? CH_DASH : CH_DOT);
                        if ($urandom_range(0, 29) == 0)
                            line_chars.push_back(8'($urandom_range(0, 255)));
                    end
                    if (t < ntok - 1)
                    begin
                        line_chars.push_back(CH_SPACE);
                        if ($urandom_range(0, 3) == 0)
                            line_chars.push_back(CH_SPACE);
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    line_chars.push_back(CH_SPACE);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    line_chars.push_back(8'($urandom_range(0, 255)));
            end
            foreach (line_chars[i])
                add_char(line_chars[i], i == line_chars.size() - 1, drain && i == 0);
            random_chars += line_chars.size();
            lines++;
        end
        total = char_queue.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (chars_taken != total || expected_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d characters over %0d encode and %0d decode lines;",
                 chars_taken, encode_lines, decode_lines);
        $display("%0d result beats checked, %0d of them flagged as errors.",
                 beats_checked, error_beats);
        $display("Codec held off its input for %0d cycles; output was held for up to %0d cycles.",
                 backpressure_cycles, LONG_HOLD);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
sv/mclc_pkg.sv
sv/mclc_core.sv
sv/mclc_outbuf.sv
sv/morse_code_line_codec.sv
verif/morse_code_line_codec_tb.sv
